// ===== hdl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int DATA_W   = 32;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = REQ_W;
	localparam int M_TDATA_W = 48;
	localparam int S_PAD_W   = S_TDATA_W - DATA_W - INDEX_W;
	localparam int M_PAD_W   = M_TDATA_W - DATA_W - STATUS_W - COUNT_W - 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_READ       = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_READ = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic exec;
		logic load_res;
		logic load_rd;
	} dp_cmd_t;

	typedef struct packed {
		logic rd_go;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/deq_ram.sv =====
`default_nettype none

module deq_ram #(
	parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/deq_dpath.sv =====
`default_nettype none

module deq_dpath #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire deq_pkg::dp_cmd_t                cmd,
	output deq_pkg::dp_stat_t                    stat,
	input  wire logic [deq_pkg::REQ_W-1:0]       req_type,
	input  wire logic [deq_pkg::DATA_W-1:0]      data_in,
	input  wire logic [deq_pkg::INDEX_W-1:0]     index,
	output logic      [deq_pkg::DATA_W-1:0]      read_data,
	output logic      [deq_pkg::STATUS_W-1:0]    status,
	output logic      [deq_pkg::COUNT_W-1:0]     count,
	output logic                                 is_empty
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;
	localparam int RSW  = ((AW > deq_pkg::INDEX_W) ? AW : deq_pkg::INDEX_W) + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	deq_pkg::status_t st;
	logic we;
	logic rd_go;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW:0] tail_sum;
	logic [AW-1:0] tail;
	logic [RSW-1:0] rsum;
	logic full;
	logic empty;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic [deq_pkg::DATA_W-1:0]   read_data_q;
	logic [deq_pkg::STATUS_W-1:0] status_q;
	logic [deq_pkg::COUNT_W-1:0]  count_out_q;
	logic                         is_empty_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
	assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
	                                               : AW'(tail_sum);
	assign rsum     = RSW'(head_q) + RSW'(index);
	assign raddr    = (rsum >= RSW'(DEPTH)) ? AW'(rsum - RSW'(DEPTH)) : AW'(rsum);

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		st      = deq_pkg::STAT_OK;
		we      = 1'b0;
		waddr   = tail;
		rd_go   = 1'b0;
		case (deq_pkg::req_t'(req_type))
			deq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					st = deq_pkg::STAT_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			deq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					st = deq_pkg::STAT_FULL;
				end else begin
					we      = 1'b1;
					waddr   = head_dec;
					head_d  = head_dec;
					count_d = count_q + 1'b1;
				end
			end
			deq_pkg::REQ_POP_BACK: begin
				if (empty) begin
					st = deq_pkg::STAT_POP_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			deq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					st = deq_pkg::STAT_POP_EMPTY;
				end else begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
				end
			end
			deq_pkg::REQ_READ: begin
				if (CMPW'(index) >= CMPW'(count_q)) begin
					st = deq_pkg::STAT_RANGE;
				end else begin
					rd_go = 1'b1;
				end
			end
			deq_pkg::REQ_CLEAR: begin
				head_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.rd_go = rd_go;

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec & we),
		.waddr (waddr),
		.wdata (DATA_WIDTH'(data_in)),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			read_data_q <= '0;
			status_q    <= st;
			count_out_q <= deq_pkg::COUNT_W'(count_d);
			is_empty_q  <= (count_d == '0);
		end else if (cmd.load_rd) begin
			read_data_q <= deq_pkg::DATA_W'(ram_rdata);
			status_q    <= deq_pkg::STAT_OK;
			count_out_q <= deq_pkg::COUNT_W'(count_q);
			is_empty_q  <= empty;
		end
	end

	assign read_data = read_data_q;
	assign status    = status_q;
	assign count     = count_out_q;
	assign is_empty  = is_empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(head_q) < (CW+1)'(DEPTH))
		else $error("head pointer out of ring");

endmodule

`default_nettype wire

// ===== hdl/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	output logic                   s_ready,
	output logic                   m_valid,
	input  wire logic              m_ready,
	output deq_pkg::dp_cmd_t       cmd,
	input  wire deq_pkg::dp_stat_t stat
);

	deq_pkg::ctrl_state_t state_q;
	deq_pkg::ctrl_state_t state_d;
	logic out_valid_q;
	logic out_valid_d;
	logic exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_ready      = 1'b0;
		exec         = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_res = 1'b0;
		cmd.load_rd  = 1'b0;
		out_valid_d  = out_valid_q & ~m_ready;
		case (state_q)
			deq_pkg::CS_IDLE: begin
				s_ready      = ~out_valid_q | m_ready;
				exec         = s_valid & s_ready;
				cmd.exec     = exec;
				cmd.load_res = exec & ~stat.rd_go;
				if (exec && !stat.rd_go) begin
					out_valid_d = 1'b1;
				end
				if (exec && stat.rd_go) begin
					state_d = deq_pkg::CS_READ;
				end
			end
			deq_pkg::CS_READ: begin
				cmd.load_rd = 1'b1;
				out_valid_d = 1'b1;
				state_d     = deq_pkg::CS_IDLE;
			end
			default: begin
				state_d = deq_pkg::CS_IDLE;
			end
		endcase
	end

	assign m_valid = out_valid_q;

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == deq_pkg::CS_READ |=> state_q == deq_pkg::CS_IDLE)
		else $error("read state held too long");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == deq_pkg::CS_READ |-> !out_valid_q)
		else $error("output word pending while ram data arrives");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_ready |-> !cmd.load_res && !cmd.load_rd)
		else $error("output word overwritten before taken");

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_buffer.sv =====
// Double-ended queue of DEPTH words kept as a ring in one RAM. Each word on the
// slave side is a request (push back, push front, pop back, pop front, read at
// an index from the front, clear); each request gives one result word with
// read data, status, element count and an empty flag. Pushes, pops, clears,
// failed reads and unused codes load the result register when accepted; a read
// that hits stored data passes a read state, as the RAM read port is registered.
// Pushing into a full queue leaves it unchanged and reports status 3; popping
// an empty one reports status 1; reading at or past the count reports status 2.
// The slave side keeps accepting while a finished result waits, as long as the
// output register is free or being taken and no read is in its read state.
`default_nettype none

module double_ended_queue_buffer #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// data_in[31:0], index[37:32], zero pad
	input  wire logic [deq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// req_type[2:0]
	input  wire logic [deq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// read_data[31:0], status[33:32], count[40:34], is_empty[41], zero pad
	output logic      [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	deq_pkg::dp_cmd_t  cmd;
	deq_pkg::dp_stat_t stat;

	logic [deq_pkg::DATA_W-1:0]   read_data;
	logic [deq_pkg::STATUS_W-1:0] status;
	logic [deq_pkg::COUNT_W-1:0]  count;
	logic                         is_empty;

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	deq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_type  (s_axis_tuser[deq_pkg::REQ_W-1:0]),
		.data_in   (s_axis_tdata[deq_pkg::DATA_W-1:0]),
		.index     (s_axis_tdata[deq_pkg::DATA_W +: deq_pkg::INDEX_W]),
		.read_data (read_data),
		.status    (status),
		.count     (count),
		.is_empty  (is_empty)
	);

	assign m_axis_tdata = {{deq_pkg::M_PAD_W{1'b0}}, is_empty, count, status, read_data};

endmodule

`default_nettype wire
